FILE: design/hcbd_pkg.sv
// ----------------------------------------------------------------------------
// hcbd_pkg
// Types, constants and helpers for the HTTP chunked body decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package hcbd_pkg;

  // Size line digit limit and derived widths
  localparam int SizeDigitsMax = 8;
  localparam int ChunkW        = 4 * SizeDigitsMax;
  localparam int DigitCntW     = $clog2(SizeDigitsMax + 1);

  // Header key, first character in the top byte
  localparam int KeyLen  = 26;
  localparam int KeyPosW = $clog2(KeyLen + 1);
  localparam logic [KeyLen*8-1:0] TeKeyStr = "Transfer-Encoding: chunked";

  localparam logic [7:0] ChCr   = 8'h0D;
  localparam logic [7:0] ChLf   = 8'h0A;
  localparam logic [7:0] ChSemi = 8'h3B;

  // Configuration register indexes
  localparam int CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CfgKeepDataCrlf = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgDecodeEnable = 1'd1;
  localparam int CfgDataW = 1;

  typedef enum logic [3:0] {
    PhHeader  = 4'd0,
    PhPass    = 4'd1,
    PhSize    = 4'd2,
    PhExt     = 4'd3,
    PhSizeLf  = 4'd4,
    PhData    = 4'd5,
    PhDataCr  = 4'd6,
    PhDataLf  = 4'd7,
    PhTrailer = 4'd8,
    PhDone    = 4'd9,
    PhError   = 4'd10
  } phase_e;

  typedef enum logic [1:0] {
    KindHeader    = 2'd0,
    KindBody      = 2'd1,
    KindEnd       = 2'd2,
    KindMalformed = 2'd3
  } kind_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_of_message;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    kind_e      kind;
    logic       chunked_seen;
  } out_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } hex_t;

  function automatic logic [7:0] key_char(input logic [KeyPosW-1:0] pos);
    int sel;
    sel = KeyLen - 1 - int'(pos);
    if (sel < 0) begin
      sel = 0;
    end
    return TeKeyStr[sel*8 +: 8];
  endfunction

  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    h.valid = 1'b1;
    h.value = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.value = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.value = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.value = 4'(c - 8'h37);
    end else begin
      h.valid = 1'b0;
    end
    return h;
  endfunction

endpackage

`default_nettype wire

FILE: design/http_chunked_body_decoder.sv
// ----------------------------------------------------------------------------
// http_chunked_body_decoder
// Byte-wide HTTP message parser: passes header bytes, detects a chunked
// transfer encoding header line and decodes or passes the body.
// ----------------------------------------------------------------------------
// Result word: registered, valid the cycle after its input word is accepted.
// Throughput: one word per cycle if not stalled; parser state updates in the
//   same cycle as the result register loads, so words may arrive back to back.
// Reset: asynchronous, active low; parser to header phase, both config
//   registers to 1, result register empty.
`default_nettype none

module http_chunked_body_decoder (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [hcbd_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [hcbd_pkg::CfgDataW-1:0]   cfg_data_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire hcbd_pkg::in_t                   in_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output hcbd_pkg::out_t                       out_o
);
  import hcbd_pkg::*;

  logic keep_crlf_q, decode_en_q;

  phase_e               phase_q, phase_d, phase_c;
  logic [ChunkW-1:0]    rem_q, rem_d, rem_c;
  logic [DigitCntW-1:0] cnt_q, cnt_d, cnt_c;
  logic [KeyPosW-1:0]   pos_q, pos_d, pos_c;
  logic                 match_q, match_d, match_c;
  logic                 chunked_q, chunked_d, chunked_c;
  logic                 empty_q, empty_d, empty_c;

  logic       in_fire;
  logic [7:0] c;
  hex_t       hx;
  logic       res_vld;
  out_t       res;
  logic       out_valid_q;
  out_t       out_q;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign c          = in_i.data_byte;
  assign hx         = hex_decode(c);

  // first_of_message restarts the parser before this byte
  always_comb begin
    if (in_i.first_of_message) begin
      phase_c   = PhHeader;
      rem_c     = '0;
      cnt_c     = '0;
      pos_c     = '0;
      match_c   = 1'b1;
      chunked_c = 1'b0;
      empty_c   = 1'b1;
    end else begin
      phase_c   = phase_q;
      rem_c     = rem_q;
      cnt_c     = cnt_q;
      pos_c     = pos_q;
      match_c   = match_q;
      chunked_c = chunked_q;
      empty_c   = empty_q;
    end
  end

  // next state
  always_comb begin
    phase_d   = phase_c;
    rem_d     = rem_c;
    cnt_d     = cnt_c;
    pos_d     = pos_c;
    match_d   = match_c;
    chunked_d = chunked_c;
    empty_d   = empty_c;
    unique case (phase_c)
      PhHeader: begin
        if (c == ChLf) begin
          if (empty_c) begin
            phase_d = (chunked_c && decode_en_q) ? PhSize : PhPass;
            rem_d   = '0;
            cnt_d   = '0;
          end else if (match_c && pos_c == KeyPosW'(KeyLen)) begin
            chunked_d = 1'b1;
          end
          pos_d   = '0;
          match_d = 1'b1;
          empty_d = 1'b1;
        end else if (c != ChCr) begin
          empty_d = 1'b0;
          if (match_c && pos_c < KeyPosW'(KeyLen)) begin
            if (c == key_char(pos_c)) begin
              pos_d = pos_c + KeyPosW'(1);
            end else begin
              match_d = 1'b0;
            end
          end
        end
      end
      PhSize: begin
        if (hx.valid) begin
          if (cnt_c >= DigitCntW'(SizeDigitsMax)) begin
            phase_d = PhError;
          end else begin
            rem_d = {rem_c[ChunkW-5:0], hx.value};
            cnt_d = cnt_c + DigitCntW'(1);
          end
        end else if (cnt_c == '0) begin
          phase_d = PhError;
        end else if (c == ChSemi) begin
          phase_d = PhExt;
        end else if (c == ChCr) begin
          phase_d = PhSizeLf;
        end else begin
          phase_d = PhError;
        end
      end
      PhExt: begin
        if (c == ChCr) begin
          phase_d = PhSizeLf;
        end else if (c == ChLf) begin
          phase_d = PhError;
        end
      end
      PhSizeLf: begin
        if (c != ChLf) begin
          phase_d = PhError;
        end else if (rem_c == '0) begin
          phase_d = PhTrailer;
          empty_d = 1'b1;
        end else begin
          phase_d = PhData;
        end
      end
      PhData: begin
        rem_d = rem_c - ChunkW'(1);
        if (rem_c == ChunkW'(1)) begin
          phase_d = PhDataCr;
        end
      end
      PhDataCr: begin
        phase_d = (c == ChCr) ? PhDataLf : PhError;
      end
      PhDataLf: begin
        if (c != ChLf) begin
          phase_d = PhError;
        end else begin
          phase_d = PhSize;
          rem_d   = '0;
          cnt_d   = '0;
        end
      end
      PhTrailer: begin
        if (c == ChLf) begin
          if (empty_c) begin
            phase_d = PhDone;
          end else begin
            empty_d = 1'b1;
          end
        end else if (c != ChCr) begin
          empty_d = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // result word
  always_comb begin
    res_vld          = 1'b0;
    res.out_byte     = 8'd0;
    res.kind         = KindMalformed;
    res.chunked_seen = chunked_d;
    unique case (phase_c) inside
      PhHeader: begin
        res_vld      = 1'b1;
        res.out_byte = c;
        res.kind     = KindHeader;
      end
      PhPass, PhData: begin
        res_vld      = 1'b1;
        res.out_byte = c;
        res.kind     = KindBody;
      end
      PhSize: begin
        if (hx.valid) begin
          res_vld = (cnt_c >= DigitCntW'(SizeDigitsMax));
        end else begin
          res_vld = (cnt_c == '0) || (c != ChSemi && c != ChCr);
        end
      end
      PhExt:    res_vld = (c == ChLf);
      PhSizeLf: res_vld = (c != ChLf);
      PhDataCr, PhDataLf: begin
        if (c != ((phase_c == PhDataCr) ? ChCr : ChLf)) begin
          res_vld = 1'b1;
        end else if (keep_crlf_q) begin
          res_vld      = 1'b1;
          res.out_byte = c;
          res.kind     = KindBody;
        end
      end
      PhTrailer: begin
        if (c == ChLf && empty_c) begin
          res_vld  = 1'b1;
          res.kind = KindEnd;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keep_crlf_q <= 1'b1;
      decode_en_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgKeepDataCrlf: keep_crlf_q <= cfg_data_i[0];
        CfgDecodeEnable: decode_en_q <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhHeader;
      rem_q     <= '0;
      cnt_q     <= '0;
      pos_q     <= '0;
      match_q   <= 1'b1;
      chunked_q <= 1'b0;
      empty_q   <= 1'b1;
    end else if (in_fire) begin
      phase_q   <= phase_d;
      rem_q     <= rem_d;
      cnt_q     <= cnt_d;
      pos_q     <= pos_d;
      match_q   <= match_d;
      chunked_q <= chunked_d;
      empty_q   <= empty_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= res_vld;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && res_vld) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // an end word always leaves the parser in the done phase
  a_end_to_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && res_vld && res.kind == KindEnd |=> phase_q == PhDone)
    else $error("end word without done phase");

  // a malformed word always leaves the parser in the error phase
  a_err_to_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && res_vld && res.kind == KindMalformed |=> phase_q == PhError)
    else $error("malformed word without error phase");

  // end of chunked body only after the chunked header was seen, with a zero byte
  a_end_chunked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.kind == KindEnd |-> out_o.chunked_seen && out_o.out_byte == 8'd0)
    else $error("end word without chunked header");

  // key position never runs past the key
  a_key_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= KeyPosW'(KeyLen))
    else $error("key position overflow");

endmodule

`default_nettype wire

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for http_chunked_body_decoder. A table of directed
// messages (extremes, header key match, size lines, trailers, framing errors)
// is followed by randomly built messages, mostly well-formed with random
// content, some corrupted, some plain noise. Each accepted word is run
// through a local decoder model and the output words are compared in order.
// Sender gaps, receiver stalls and both register settings vary per phase.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import hcbd_pkg::*;

  localparam int KeyChars    = 26;
  localparam logic [KeyChars*8-1:0] KeyText = "Transfer-Encoding: chunked";
  localparam int DigitLimit  = 8;
  localparam int CycleLimit  = 200000;
  localparam int RandomWords = 850;
  localparam int MaxShown    = 10;
  localparam int ProbeRows   = 33;
  localparam int Phases      = 4;

  logic                clk_i      = 1'b0;
  logic                rst_ni     = 1'b0;
  logic                cfg_we_i   = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i  = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  in_t                 in_i       = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  out_t                out_o;

  http_chunked_body_decoder dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_o      (out_o)
  );

  always #5ns clk_i = ~clk_i;

  // Directed stimulus: text rows are sent byte by byte (first byte carries
  // the row's sof), raw rows send one byte whose result is typed in when marked.
  typedef struct {
    logic [255:0] txt;
    logic [7:0]   raw;
    bit           use_raw;
    bit           sof;
    bit           typed;
    bit           yields;
    out_t         want;
  } probe_row_t;

  probe_row_t probe_tab [ProbeRows] = '{
    '{'0, 8'h00, 1, 1, 1, 1, '{8'h00, KindHeader, 1'b0}},
    '{'0, 8'hFF, 1, 0, 1, 1, '{8'hFF, KindHeader, 1'b0}},
    '{"\r\n", 8'h00, 0, 0, 0, 0, '0},
    '{"Transfer-Encoding: chunked;x\r\n", 8'h00, 0, 0, 0, 0, '0},
    '{"\n", 8'h00, 0, 0, 0, 0, '0},
    '{"1f;ext=1\r\n", 8'h00, 0, 0, 0, 0, '0},
    '{"0123456789abcdefghijklmnopqrstu", 8'h00, 0, 0, 0, 0, '0},
    '{"\r\n", 8'h00, 0, 0, 0, 0, '0},
    '{"0000000A\r\n", 8'h00, 0, 0, 0, 0, '0},
    '{"ABCDEFGHIJ\r\n", 8'h00, 0, 0, 0, 0, '0},
    '{"0;z\r\nTrl: 1\r\n\r", 8'h00, 0, 0, 0, 0, '0},
    '{'0, ChLf, 1, 0, 1, 1, '{8'h00, KindEnd, 1'b1}},
    '{"zz", 8'h00, 0, 0, 0, 0, '0},
    '{"\r\n", 8'h00, 0, 1, 0, 0, '0},
    '{'0, 8'hFF, 1, 0, 1, 1, '{8'hFF, KindBody, 1'b0}},
    '{"transfer-Encoding: chunked\r\n\r\n", 8'h00, 0, 1, 0, 0, '0},
    '{'0, 8'h00, 1, 0, 1, 1, '{8'h00, KindBody, 1'b0}},
    '{"Transfer-Encoding: chunked\r\n\r\n", 8'h00, 0, 1, 0, 0, '0},
    '{"ABCDEF01", 8'h00, 0, 0, 0, 0, '0},
    '{'0, "2", 1, 0, 1, 1, '{8'h00, KindMalformed, 1'b1}},
    '{"xx", 8'h00, 0, 0, 0, 0, '0},
    '{"Transfer-Encoding: chunked\r\n\r\n", 8'h00, 0, 1, 0, 0, '0},
    '{'0, ChSemi, 1, 0, 1, 1, '{8'h00, KindMalformed, 1'b1}},
    '{"Transfer-Encoding: chunked\r\n\r\n5\r", 8'h00, 0, 1, 0, 0, '0},
    '{'0, "X", 1, 0, 1, 1, '{8'h00, KindMalformed, 1'b1}},
    '{"Transfer-Encoding: chunked\r\n\r\n", 8'h00, 0, 1, 0, 0, '0},
    '{"2\r\nab", 8'h00, 0, 0, 0, 0, '0},
    '{'0, "X", 1, 0, 1, 1, '{8'h00, KindMalformed, 1'b1}},
    '{"Transfer-Encoding: chunked\r\n\r\n", 8'h00, 0, 1, 0, 0, '0},
    '{"1;e", 8'h00, 0, 0, 0, 0, '0},
    '{'0, ChLf, 1, 0, 1, 1, '{8'h00, KindMalformed, 1'b1}},
    '{"Transfer-Encoding: chunked\r\n\r\n", 8'h00, 0, 1, 0, 0, '0},
    '{'0, "g", 1, 0, 1, 1, '{8'h00, KindMalformed, 1'b1}}
  };

  int gap_tab   [Phases] = '{0, 77, 0, 21};
  int stall_tab [Phases] = '{0, 0, 77, 21};
  bit keep_tab  [Phases] = '{1, 0, 1, 0};
  bit dec_tab   [Phases] = '{1, 1, 0, 1};

  int   gap_pct   = 0;
  int   stall_pct = 0;
  int   bad_words = 0;
  int unsigned cycles = 0;
  out_t expected_words [$];
  in_t  msg_q [$];

  // typed expectation for the word currently on the input
  bit   use_typed    = 1'b0;
  bit   typed_yields = 1'b0;
  out_t typed_word   = '0;

  // decoder model state
  phase_e           ph_m;
  logic [ChunkW-1:0] left_m;
  logic [3:0]       ndig_m;
  logic [4:0]       keypos_m;
  logic             keyok_m;
  logic             chunked_m;
  logic             blank_m;
  logic             keep_crlf_m;
  logic             decode_en_m;

  task automatic clear_parse_state();
    ph_m      = PhHeader;
    left_m    = '0;
    ndig_m    = '0;
    keypos_m  = '0;
    keyok_m   = 1'b1;
    chunked_m = 1'b0;
    blank_m   = 1'b1;
  endtask

  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    if (c >= "0" && c <= "9") begin
      return {1'b1, 4'(c - "0")};
    end else if (c >= "a" && c <= "f") begin
      return {1'b1, 4'(c - "a" + 8'd10)};
    end else if (c >= "A" && c <= "F") begin
      return {1'b1, 4'(c - "A" + 8'd10)};
    end
    return 5'd0;
  endfunction

  function automatic out_t word_of(input logic [7:0] b, input kind_e k);
    out_t w;
    w.out_byte     = b;
    w.kind         = k;
    w.chunked_seen = chunked_m;
    return w;
  endfunction

  task automatic malformed_word(output bit yields, output out_t res);
    ph_m   = PhError;
    yields = 1'b1;
    res    = word_of(8'h00, KindMalformed);
  endtask

  task automatic decode_byte(input in_t w, output bit yields, output out_t res);
    logic [7:0] c;
    logic [4:0] hx;
    c      = w.data_byte;
    yields = 1'b0;
    res    = '0;
    if (w.first_of_message) begin
      clear_parse_state();
    end
    case (ph_m)
      PhHeader: begin
        if (c == ChLf) begin
          if (blank_m) begin
            ph_m   = (chunked_m && decode_en_m) ? PhSize : PhPass;
            left_m = '0;
            ndig_m = '0;
          end else if (keyok_m && keypos_m == KeyChars) begin
            chunked_m = 1'b1;
          end
          keypos_m = '0;
          keyok_m  = 1'b1;
          blank_m  = 1'b1;
        end else if (c != ChCr) begin
          blank_m = 1'b0;
          if (keyok_m && keypos_m < KeyChars) begin
            if (c == KeyText[(KeyChars - 1 - int'(keypos_m)) * 8 +: 8]) begin
              keypos_m++;
            end else begin
              keyok_m = 1'b0;
            end
          end
        end
        yields = 1'b1;
        res    = word_of(c, KindHeader);
      end
      PhPass: begin
        yields = 1'b1;
        res    = word_of(c, KindBody);
      end
      PhSize: begin
        hx = hex_nibble(c);
        if (hx[4]) begin
          if (ndig_m >= DigitLimit) begin
            malformed_word(yields, res);
          end else begin
            left_m = {left_m[ChunkW-5:0], hx[3:0]};
            ndig_m++;
          end
        end else if (ndig_m == 0 || !(c == ChSemi || c == ChCr)) begin
          malformed_word(yields, res);
        end else if (c == ChSemi) begin
          ph_m = PhExt;
        end else begin
          ph_m = PhSizeLf;
        end
      end
      PhExt: begin
        if (c == ChCr) begin
          ph_m = PhSizeLf;
        end else if (c == ChLf) begin
          malformed_word(yields, res);
        end
      end
      PhSizeLf: begin
        if (c != ChLf) begin
          malformed_word(yields, res);
        end else if (left_m == 0) begin
          ph_m    = PhTrailer;
          blank_m = 1'b1;
        end else begin
          ph_m = PhData;
        end
      end
      PhData: begin
        left_m--;
        if (left_m == 0) begin
          ph_m = PhDataCr;
        end
        yields = 1'b1;
        res    = word_of(c, KindBody);
      end
      PhDataCr: begin
        if (c != ChCr) begin
          malformed_word(yields, res);
        end else begin
          ph_m   = PhDataLf;
          yields = keep_crlf_m;
          res    = word_of(c, KindBody);
        end
      end
      PhDataLf: begin
        if (c != ChLf) begin
          malformed_word(yields, res);
        end else begin
          ph_m   = PhSize;
          left_m = '0;
          ndig_m = '0;
          yields = keep_crlf_m;
          res    = word_of(c, KindBody);
        end
      end
      PhTrailer: begin
        if (c == ChLf) begin
          if (blank_m) begin
            ph_m   = PhDone;
            yields = 1'b1;
            res    = word_of(8'h00, KindEnd);
          end else begin
            blank_m = 1'b1;
          end
        end else if (c != ChCr) begin
          blank_m = 1'b0;
        end
      end
      default: begin
      end
    endcase
  endtask

  // Result check, register shadow and model update, all on the rising edge.
  always @(posedge clk_i) begin
    out_t want;
    out_t pred;
    bit   yields;
    if (!rst_ni) begin
      keep_crlf_m = 1'b1;
      decode_en_m = 1'b1;
      clear_parse_state();
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_words.size() == 0) begin
          bad_words++;
          if (bad_words <= MaxShown) begin
            $display("unexpected word: byte %02h kind %0d flag %0b",
                     out_o.out_byte, out_o.kind, out_o.chunked_seen);
          end
        end else begin
          want = expected_words.pop_front();
          if (out_o.out_byte !== want.out_byte || out_o.kind !== want.kind ||
              out_o.chunked_seen !== want.chunked_seen) begin
            bad_words++;
            if (bad_words <= MaxShown) begin
              $display("mismatch: expected %02h/%0d/%0b, got %02h/%0d/%0b",
                       want.out_byte, want.kind, want.chunked_seen,
                       out_o.out_byte, out_o.kind, out_o.chunked_seen);
            end
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgKeepDataCrlf: keep_crlf_m = cfg_data_i[0];
          CfgDecodeEnable: decode_en_m = cfg_data_i[0];
          default: begin
          end
        endcase
      end
      if (in_valid_i && in_ready_o) begin
        decode_byte(in_i, yields, pred);
        if (use_typed) begin
          yields = typed_yields;
          pred   = typed_word;
        end
        if (yields) begin
          expected_words.push_back(pred);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    out_ready_i <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
  end

  task automatic send_word(input in_t w, input bit typed, input bit yields, input out_t want);
    @(negedge clk_i);
    while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    in_i         <= w;
    use_typed    = typed;
    typed_yields = yields;
    typed_word   = want;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Holds the sender until every expected word is back, then lets the
  // result register settle in case the last word gave no result.
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= CfgDataW'(val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  task automatic add_byte(input logic [7:0] b);
    in_t w;
    w.data_byte        = b;
    w.first_of_message = 1'b0;
    msg_q.push_back(w);
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      add_byte(s[i]);
    end
  endtask

  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    b = 8'($urandom);
    if (b == ChCr || b == ChLf) begin
      b = "a";
    end
    return b;
  endfunction

  task automatic add_line_end();
    if ($urandom_range(3) == 0) begin
      add_byte(ChLf);
    end else begin
      add_text("\r\n");
    end
  endtask

  task automatic add_filler_line();
    repeat ($urandom_range(1, 8)) add_byte(text_byte());
    add_line_end();
  endtask

  task automatic add_key(input int n);
    for (int p = 0; p < n; p++) begin
      add_byte(KeyText[(KeyChars - 1 - p) * 8 +: 8]);
    end
  endtask

  task automatic add_size_line(input int sz);
    int md;
    int nd;
    logic [3:0] nib;
    md = 1;
    while ((sz >> (4 * md)) != 0) md++;
    nd = md;
    if ($urandom_range(3) == 0) begin
      nd = $urandom_range(md, DigitLimit);
    end
    if ($urandom_range(29) == 0) begin
      nd = DigitLimit + 1;
    end
    for (int i = nd - 1; i >= 0; i--) begin
      nib = (i < 8) ? 4'(sz >> (4 * i)) : 4'd0;
      if (nib < 10) begin
        add_byte(8'("0" + nib));
      end else begin
        add_byte(8'(($urandom_range(1) ? "A" : "a") + nib - 10));
      end
    end
    if ($urandom_range(3) == 0) begin
      add_byte(ChSemi);
      repeat ($urandom_range(0, 6)) add_byte(text_byte());
    end
    add_text("\r\n");
  endtask

  // One random message in msg_q: mostly a well-formed chunked message with
  // random content, sometimes a plain body, a corrupted byte, or pure noise.
  task automatic build_message();
    int   at;
    int   kv;
    int   sz;
    in_t  w;
    msg_q.delete();
    if ($urandom_range(99) < 8) begin
      repeat ($urandom_range(1, 24)) begin
        w.data_byte        = 8'($urandom);
        w.first_of_message = ($urandom_range(7) == 0);
        msg_q.push_back(w);
      end
      return;
    end
    repeat ($urandom_range(0, 2)) add_filler_line();
    if ($urandom_range(99) < 85) begin
      kv = $urandom_range(9);
      at = msg_q.size();
      if (kv == 0) begin
        add_key($urandom_range(1, KeyChars - 1));
      end else begin
        add_key(KeyChars);
      end
      if (kv == 1) begin
        at = at + $urandom_range(KeyChars - 1);
        w = msg_q[at];
        w.data_byte ^= 8'h20;
        msg_q[at] = w;
      end
      if (kv == 2) begin
        add_text(";q=1");
      end
      add_line_end();
    end
    repeat ($urandom_range(0, 1)) add_filler_line();
    add_line_end();
    if ($urandom_range(99) < 15) begin
      repeat ($urandom_range(1, 12)) add_byte(8'($urandom));
    end else begin
      repeat ($urandom_range(0, 3)) begin
        sz = ($urandom_range(9) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 6);
        add_size_line(sz);
        repeat (sz) add_byte(8'($urandom));
        add_text("\r\n");
      end
      add_size_line(0);
      repeat ($urandom_range(0, 2)) add_filler_line();
      add_line_end();
      repeat ($urandom_range(0, 2)) add_byte(8'($urandom));
    end
    if ($urandom_range(99) < 12) begin
      at = $urandom_range(msg_q.size() - 1);
      w = msg_q[at];
      w.data_byte = 8'($urandom);
      msg_q[at] = w;
    end
    w = msg_q[0];
    w.first_of_message = 1'b1;
    msg_q[0] = w;
  endtask

  initial begin
    int   top;
    int   sent;
    bit   paused;
    in_t  w;
    logic [255:0] txt;
    paused = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (probe_tab[i]) begin
      if (probe_tab[i].use_raw) begin
        w.data_byte        = probe_tab[i].raw;
        w.first_of_message = probe_tab[i].sof;
        send_word(w, probe_tab[i].typed, probe_tab[i].yields, probe_tab[i].want);
      end else begin
        txt = probe_tab[i].txt;
        top = 31;
        while (top > 0 && txt[top*8 +: 8] == 8'h00) top--;
        for (int k = top; k >= 0; k--) begin
          w.data_byte        = txt[k*8 +: 8];
          w.first_of_message = probe_tab[i].sof && (k == top);
          send_word(w, 1'b0, 1'b0, '0);
        end
      end
    end

    for (int p = 0; p < Phases; p++) begin
      wait_idle();
      gap_pct   = gap_tab[p];
      stall_pct = stall_tab[p];
      write_reg(CfgKeepDataCrlf, keep_tab[p]);
      write_reg(CfgDecodeEnable, dec_tab[p]);
      sent = 0;
      while (sent < RandomWords / Phases) begin
        build_message();
        foreach (msg_q[j]) begin
          send_word(msg_q[j], 1'b0, 1'b0, '0);
        end
        sent += msg_q.size();
        // sender holds until the output side has fully drained
        if (p == 1 && !paused && sent > 100) begin
          paused = 1'b1;
          wait_idle();
        end
      end
    end

    wait_idle();
    if (bad_words == 0 && expected_words.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/hcbd_pkg.sv
design/http_chunked_body_decoder.sv
test/testbench.sv
